// ===== rtl/esd_pkg.sv =====
// Shared types and constants of the escape sequence decoder.
package esd_pkg;

    // Decoder modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_DIGITS = 2'd2;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MISSING   = 2'd1;
    localparam logic [1:0] ST_OVER      = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    // Input characters
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_B    = 8'h62;
    localparam logic [7:0] CH_F    = 8'h66;
    localparam logic [7:0] CH_N    = 8'h6E;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_T    = 8'h74;

    // Decoded control bytes
    localparam logic [7:0] BYTE_BS  = 8'd8;
    localparam logic [7:0] BYTE_TAB = 8'd9;
    localparam logic [7:0] BYTE_LF  = 8'd10;
    localparam logic [7:0] BYTE_FF  = 8'd12;
    localparam logic [7:0] BYTE_CR  = 8'd13;

    // Limits
    localparam logic [7:0] CTRL_MAX  = 8'd31;
    localparam logic [7:0] DEL_BYTE  = 8'd127;
    localparam logic [9:0] BYTE_MAX  = 10'd255;
    localparam logic [1:0] RUN_MAX   = 2'd3;

    // One result item
    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } result_t;

    // All results caused by one input byte; cnt is 0..3
    typedef struct packed {
        logic [1:0]        cnt;
        result_t [2:0]     res;
    } bundle_t;

    // Decoder state
    typedef struct packed {
        logic [1:0] mode;
        logic [9:0] value;
        logic [1:0] count;
        logic       dropping;
    } dec_state_t;

endpackage

// ===== rtl/esd_decode.sv =====
// Combinational decode of one byte against the decoder state.
module esd_decode import esd_pkg::*; (
    input  logic [7:0] data_byte,
    input  logic       is_last,
    input  dec_state_t state_i,
    output dec_state_t state_o,
    output bundle_t    bundle_o
);

    logic       is_dec;
    logic [3:0] digit;
    logic [9:0] folded;

    assign is_dec = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign digit  = 4'(data_byte - CH_ZERO);
    assign folded = {state_i.value[6:0], 3'b000} | {6'b0, digit};

    always_comb begin
        dec_state_t st;
        result_t [2:0] res;
        logic [1:0] n;
        logic [1:0] err;
        logic       used;
        logic [9:0] run_val;
        logic [7:0] esc_byte;
        logic       esc_bad;

        st       = state_i;
        res      = '0;
        n        = 2'd0;
        err      = ST_OK;
        used     = 1'b0;
        run_val  = 10'd0;
        esc_byte = data_byte;
        esc_bad  = 1'b0;

        if (st.dropping) begin
            // Drop the rest of a failed string
            if (is_last) begin
                st.dropping = 1'b0;
            end
        end else begin
            // Extend or close an open digit run
            if (st.mode[1]) begin
                if (is_dec && st.count != RUN_MAX) begin
                    used     = 1'b1;
                    st.value = folded;
                    st.count = st.count + 2'd1;
                end
                if (!used || st.count == RUN_MAX) begin
                    run_val  = st.value;
                    st.mode  = MODE_NORMAL;
                    st.value = 10'd0;
                    st.count = 2'd0;
                    if (run_val > BYTE_MAX) begin
                        err = ST_OVER;
                    end else begin
                        res[n] = '{kind: KIND_DATA, out_byte: run_val[7:0],
                                   status: ST_OK, last: 1'b0};
                        n = n + 2'd1;
                    end
                end
            end

            // Decode the byte itself
            if (err == ST_OK && !used) begin
                if (st.mode == MODE_NORMAL) begin
                    if (data_byte == CH_BSL) begin
                        st.mode = MODE_ESC;
                    end else begin
                        res[n] = '{kind: KIND_DATA, out_byte: data_byte,
                                   status: ST_OK, last: 1'b0};
                        n = n + 2'd1;
                    end
                end else if (is_dec) begin
                    st.mode  = MODE_DIGITS;
                    st.value = {6'b0, digit};
                    st.count = 2'd1;
                end else begin
                    st.mode = MODE_NORMAL;
                    case (data_byte)
                        CH_B:    esc_byte = BYTE_BS;
                        CH_F:    esc_byte = BYTE_FF;
                        CH_N:    esc_byte = BYTE_LF;
                        CH_R:    esc_byte = BYTE_CR;
                        CH_T:    esc_byte = BYTE_TAB;
                        default: esc_bad = (data_byte <= CTRL_MAX) || data_byte[7]
                                           || (data_byte == DEL_BYTE);
                    endcase
                    if (esc_bad) begin
                        err = ST_MALFORMED;
                    end else begin
                        res[n] = '{kind: KIND_DATA, out_byte: esc_byte,
                                   status: ST_OK, last: 1'b0};
                        n = n + 2'd1;
                    end
                end
            end

            // Close pending escape or run at end of string
            if (err == ST_OK && is_last) begin
                if (st.mode == MODE_ESC) begin
                    err = ST_MISSING;
                end else if (st.mode[1]) begin
                    run_val = st.value;
                    if (run_val > BYTE_MAX) begin
                        err = ST_OVER;
                    end else begin
                        res[n] = '{kind: KIND_DATA, out_byte: run_val[7:0],
                                   status: ST_OK, last: 1'b0};
                        n = n + 2'd1;
                    end
                end
                st.mode  = MODE_NORMAL;
                st.value = 10'd0;
                st.count = 2'd0;
            end

            // Append the closing status
            if (err != ST_OK) begin
                st.mode     = MODE_NORMAL;
                st.value    = 10'd0;
                st.count    = 2'd0;
                st.dropping = !is_last;
                res[n] = '{kind: KIND_STATUS, out_byte: 8'd0, status: err, last: 1'b1};
                n = n + 2'd1;
            end else if (is_last) begin
                res[n] = '{kind: KIND_STATUS, out_byte: 8'd0, status: ST_OK, last: 1'b1};
                n = n + 2'd1;
            end
        end

        state_o      = st;
        bundle_o.cnt = n;
        bundle_o.res = res;
    end

endmodule

// ===== rtl/esd_result_queue.sv =====
// Two-entry queue of result bundles, served one result per request.
module esd_result_queue import esd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push_valid,
    input  bundle_t push_bundle,
    output logic    push_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    bundle_t    mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] idx_reg, idx_next;
    bundle_t    head;
    logic       fire;
    logic       pop;
    logic       push;

    assign head       = mem[rd_ptr_reg];
    assign push_ready = (count_reg != 2'd2);
    assign push       = push_valid && push_ready;
    assign out_valid  = (count_reg != 2'd0);
    assign out_res    = head.res[idx_reg];
    assign fire       = out_valid && out_ready;
    assign pop        = fire && (idx_reg == head.cnt - 2'd1);

    // Advance pointers, fill count and result index
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        idx_next    = pop ? 2'd0 : (fire ? idx_reg + 2'd1 : idx_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            idx_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
        end
    end

    // Store an incoming bundle
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_bundle;
        end
    end

endmodule

// ===== rtl/escape_sequence_decoder.sv =====
// Top level of the escaped string decoder.
//
// Input channel s_: one raw byte of an escaped string per request, s_tlast
// marks the final byte of the string. Output channel m_: one result per
// request; m_tuser is 0 for a decoded byte and 1 for the status that closes a
// string, which always carries m_tlast = 1 and the status code in tdata.
// Each request is registered on entry, decoded combinationally against the
// escape state, and any results (up to three) go as one bundle into a
// two-entry result queue. The first result of a request passes the input
// register and the queue before it can be taken. The block takes one
// request per clock while each gives at most one result and m_tready stays
// high; a request with two or three results holds the output for one
// transfer per result, since the output port moves one result per clock.
// Requests dropped after an error give no result and still pass at one per clock.
// Reset clears the escape state, the valid flag of the input register and the queue.
// When the receiver stalls, the queue fills with two bundles and s_tready
// falls as soon as the registered request has results that do not fit;
// no request or result is lost.
module escape_sequence_decoder import esd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] status, [15:10] zero
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    dec_state_t state_reg, state_next;
    bundle_t    bundle;
    logic       push_ready;
    logic       advance;
    logic       push;
    logic       s_accept;
    result_t    out_res;

    esd_decode u_decode (
        .data_byte (in_byte_reg),
        .is_last   (in_last_reg),
        .state_i   (state_reg),
        .state_o   (state_next),
        .bundle_o  (bundle)
    );

    esd_result_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_valid  (push),
        .push_bundle (bundle),
        .push_ready  (push_ready),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (out_res)
    );

    // Hand the registered byte to the decoder when its results fit
    assign advance  = in_valid_reg && ((bundle.cnt == 2'd0) || push_ready);
    assign push     = advance && (bundle.cnt != 2'd0);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '{mode: MODE_NORMAL, value: 10'd0, count: 2'd0,
                              dropping: 1'b0};
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Capture the input byte
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Pack the result
    assign m_tdata = {6'b0, out_res.status, out_res.out_byte};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

    // A status result always closes the string
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_STATUS) |-> m_tlast)
        else $error("status result without last");

    // A data result carries no status and never closes the string
    a_data_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_DATA) |-> (m_tdata[9:8] == ST_OK) && !m_tlast)
        else $error("data result with status or last");

    // Dropped bytes give no results
    a_drop_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && state_reg.dropping |-> !push)
        else $error("result pushed while dropping");

    // A digit run count is held exactly while inside a run
    a_run_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.mode == MODE_DIGITS) == (state_reg.count != 2'd0))
        else $error("digit count out of step with mode");

endmodule

// ===== dv/escape_sequence_decoder_test.sv =====
// Self-checking testbench of the escape sequence decoder, with its own model of the escape state.
import esd_pkg::*;

// Scoreboard: models the decoder state and keeps the results still due from the block
class decode_scoreboard;
    result_t     expected_q[$];
    logic [1:0]  mode;
    logic [9:0]  value;
    logic [1:0]  count;
    bit          dropping;
    int unsigned mismatches;

    function new();
        mode       = MODE_NORMAL;
        value      = '0;
        count      = '0;
        dropping   = 1'b0;
        mismatches = 0;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    // Queue one expected result; status results always close the string
    function void add_result(logic kind, logic [7:0] b, logic [1:0] st);
        result_t r;
        r.kind     = kind;
        r.out_byte = b;
        r.status   = st;
        r.last     = kind;
        expected_q = {expected_q, r};
    endfunction

    function void clear_run();
        mode  = MODE_NORMAL;
        value = '0;
        count = '0;
    endfunction

    // Close a digit run: emit its value, or report it as too large
    function logic [1:0] close_run();
        logic [9:0] v;
        v = value;
        clear_run();
        if (v > BYTE_MAX)
            return ST_OVER;
        add_result(KIND_DATA, v[7:0], ST_OK);
        return ST_OK;
    endfunction

    // Advance the model by one accepted request
    function void note_request(logic [7:0] b, logic lst);
        logic [1:0] err;
        logic [7:0] d;
        logic [3:0] dval;
        bit         used;
        bit         digit;
        err   = ST_OK;
        used  = 1'b0;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        dval  = 4'(b - CH_ZERO);

        // drop the rest of a string after an error
        if (dropping) begin
            if (lst)
                dropping = 1'b0;
            return;
        end

        // extend or close a digit run
        if (mode >= MODE_DIGITS) begin
            if (digit && count < RUN_MAX) begin
                value = {value[6:0], 3'b000} | {6'b0, dval};
                count = count + 2'd1;
                used  = 1'b1;
                if (count >= RUN_MAX)
                    err = close_run();
            end else begin
                err = close_run();
            end
        end

        // decode the byte in normal or escape mode
        if (err == ST_OK && !used) begin
            if (mode == MODE_NORMAL) begin
                if (b == CH_BSL)
                    mode = MODE_ESC;
                else
                    add_result(KIND_DATA, b, ST_OK);
            end else if (digit) begin
                mode  = MODE_DIGITS;
                value = {6'b0, dval};
                count = 2'd1;
            end else begin
                mode = MODE_NORMAL;
                case (b)
                    CH_B:    d = BYTE_BS;
                    CH_F:    d = BYTE_FF;
                    CH_N:    d = BYTE_LF;
                    CH_R:    d = BYTE_CR;
                    CH_T:    d = BYTE_TAB;
                    default: d = b;
                endcase
                if (b <= CTRL_MAX || b[7] || b == DEL_BYTE)
                    err = ST_MALFORMED;
                else
                    add_result(KIND_DATA, d, ST_OK);
            end
        end

        // close the string on its last byte
        if (err == ST_OK && lst) begin
            if (mode == MODE_ESC) begin
                err = ST_MISSING;
                clear_run();
            end else if (mode >= MODE_DIGITS) begin
                err = close_run();
            end
        end

        if (err != ST_OK) begin
            clear_run();
            dropping = !lst;
            add_result(KIND_STATUS, 8'h00, err);
        end else if (lst) begin
            add_result(KIND_STATUS, 8'h00, ST_OK);
        end
    endfunction

    // Compare one result from the block with the oldest expectation
    function void check_result(result_t got, logic [5:0] pad);
        result_t want;
        if (expected_q.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected result: kind %0d byte %02h status %0d last %0d",
                         got.kind, got.out_byte, got.status, got.last);
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
            got.status !== want.status || got.last !== want.last || pad !== 6'd0) begin
            if (mismatches < 10)
                $display({"mismatch: expected kind %0d byte %02h status %0d last %0d,",
                          " got kind %0d byte %02h status %0d last %0d pad %02h"},
                         want.kind, want.out_byte, want.status, want.last,
                         got.kind, got.out_byte, got.status, got.last, pad);
            mismatches++;
        end
    endfunction
endclass

module escape_sequence_decoder_test;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 260;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned DIRECTED_LEN = 25;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    decode_scoreboard sb;

    logic [7:0]  str_q[$];
    int unsigned taken_count;
    int unsigned burst_left;
    int unsigned rx_cycle;
    int unsigned hold_left;
    bit          hold_req;

    // Escape letters that decode to a control byte or to themselves
    logic [7:0] esc_letters [8] = '{CH_BSL, 8'h27, 8'h22, CH_B, CH_F, CH_N, CH_R, CH_T};

    // Directed strings, bit 8 marks the last byte
    logic [8:0] plan [DIRECTED_LEN] = '{
        // extremes of a plain byte
        {1'b0, 8'h00}, {1'b1, 8'hFF},
        // escape letter and escaped quote
        {1'b0, CH_BSL}, {1'b0, CH_N}, {1'b0, CH_BSL}, {1'b1, 8'h22},
        // three-digit run ending on its own, then a plain byte
        {1'b0, CH_BSL}, {1'b0, 8'h31}, {1'b0, 8'h32}, {1'b0, 8'h33}, {1'b1, 8'h78},
        // digit run over 255, the rest dropped
        {1'b0, CH_BSL}, {1'b0, 8'h39}, {1'b0, 8'h39}, {1'b0, 8'h39}, {1'b1, 8'h71},
        // run closed by a non-digit on the last byte: three results in one step
        {1'b0, CH_BSL}, {1'b0, 8'h31}, {1'b1, 8'h41},
        // trailing backslash
        {1'b1, CH_BSL},
        // control byte after a backslash, rest dropped
        {1'b0, CH_BSL}, {1'b0, 8'h1F}, {1'b1, 8'h61},
        // delete byte after a backslash
        {1'b0, CH_BSL}, {1'b1, DEL_BYTE}
    };

    escape_sequence_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Stall the receiver on a pattern chosen by rx_cycle[8:7], or hold it off on request
    always @(posedge aclk) begin
        rx_cycle++;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_cycle[8:7])
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= 1'($urandom_range(0, 1));
                2'd2:    m_tready <= (rx_cycle[1:0] == 2'd0);
                default: m_tready <= ($urandom_range(0, 99) < 85);
            endcase
        end
    end

    // Check each result on the falling edge before the rising edge that takes it
    always @(negedge aclk) begin
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind     = m_tuser;
            got.out_byte = m_tdata[7:0];
            got.status   = m_tdata[9:8];
            got.last     = m_tlast;
            sb.check_result(got, m_tdata[15:10]);
        end
    end

    // End the run if it hangs
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("escape_sequence_decoder_test NOT OK");
        $finish;
    end

    // Offer one request, wait for its handshake, then pace the sender in bursts
    task automatic send_request(input logic [7:0] b, input logic lst);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        sb.note_request(b, lst);
        taken_count++;
        burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5))
                @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Hold the sender until every expected result has come
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Build one random string: mostly well-formed escapes, some noise
    task automatic build_string();
        int unsigned n_tok;
        int unsigned pick;
        logic [7:0]  b;
        str_q.delete();
        if ($urandom_range(0, 99) < 15) begin
            n_tok = $urandom_range(1, 10);
            repeat (n_tok)
                str_q = {str_q,
                         ($urandom_range(0, 99) < 30) ? CH_BSL : 8'($urandom_range(0, 255))};
        end else begin
            n_tok = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
            repeat (n_tok) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    b = 8'($urandom_range(32, 126));
                    str_q = {str_q, (b == CH_BSL) ? 8'h5B : b};
                end else if (pick < 45) begin
                    b = 8'($urandom_range(0, 255));
                    str_q = {str_q, (b == CH_BSL) ? 8'h00 : b};
                end else if (pick < 65) begin
                    str_q = {str_q, CH_BSL};
                    str_q = {str_q, esc_letters[$urandom_range(0, 7)]};
                end else if (pick < 85) begin
                    str_q = {str_q, CH_BSL};
                    repeat ($urandom_range(1, 3))
                        str_q = {str_q, 8'(CH_ZERO + 8'($urandom_range(0, 9)))};
                end else if (pick < 95) begin
                    str_q = {str_q, CH_BSL};
                    str_q = {str_q, 8'($urandom_range(0, 255))};
                end else begin
                    str_q = {str_q, CH_BSL};
                end
            end
        end
    endtask

    initial begin
        int unsigned str_idx;
        sb          = new();
        taken_count = 0;
        rx_cycle    = 0;
        hold_left   = 0;
        hold_req    = 1'b0;
        burst_left  = 1;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= 8'h00;
        s_tlast     <= 1'b0;
        m_tready    <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed strings
        foreach (plan[i])
            send_request(plan[i][7:0], plan[i][8]);
        drain_results();

        // random strings, with a long receiver hold-off and a full drain on the way
        str_idx = 0;
        while (taken_count < RANDOM_ITEMS) begin
            build_string();
            foreach (str_q[i])
                send_request(str_q[i], i == str_q.size() - 1);
            str_idx++;
            if (str_idx == 6)
                hold_req = 1'b1;
            if (str_idx == 20)
                drain_results();
        end

        drain_results();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("escape_sequence_decoder_test OK");
        else
            $display("escape_sequence_decoder_test NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/esd_pkg.sv
rtl/esd_decode.sv
rtl/esd_result_queue.sv
rtl/escape_sequence_decoder.sv
dv/escape_sequence_decoder_test.sv
